@@ rtl/core/ideq_pkg.sv @@
// shared types, sizes and command codes of the indexed double-ended queue
// no dependencies
package ideq_pkg;

    localparam int DEPTH       = 256;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_W       = 8;
    localparam int CNT_W       = 9;
    localparam int LO_W        = 4;
    localparam int HI_W        = IDX_W - LO_W;
    localparam int NGRP        = 1 << HI_W;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;

    localparam logic [3:0] CMD_PUSH_TAIL  = 4'd0;
    localparam logic [3:0] CMD_PUSH_HEAD  = 4'd1;
    localparam logic [3:0] CMD_POP_TAIL   = 4'd2;
    localparam logic [3:0] CMD_POP_HEAD   = 4'd3;
    localparam logic [3:0] CMD_READ       = 4'd4;
    localparam logic [3:0] CMD_WRITE      = 4'd5;
    localparam logic [3:0] CMD_INSERT     = 4'd6;
    localparam logic [3:0] CMD_REMOVE     = 4'd7;
    localparam logic [3:0] CMD_SWAP       = 4'd8;
    localparam logic [3:0] CMD_CLEAR      = 4'd9;
    localparam logic [3:0] CMD_PEEK_FRONT = 4'd10;
    localparam logic [3:0] CMD_PEEK_BACK  = 4'd11;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // what every cell does on the next edge
    typedef enum logic [1:0] {
        K_HOLD   = 2'd0,
        K_WRITE  = 2'd1,
        K_INSERT = 2'd2,
        K_REMOVE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_idx  pos_a;
        t_idx  pos_b;
        t_word word_a;
        t_word word_b;
    } t_cell_ctrl;

endpackage

@@ rtl/core/ideq_cell.sv @@
// one storage cell of the queue row, holding the entry at its position
// depends on ideq_pkg
module ideq_cell (
    input  logic                   i_clk,
    input  ideq_pkg::t_idx         i_pos,
    input  ideq_pkg::t_cell_ctrl   i_ctrl,
    input  ideq_pkg::t_word        i_from_low,
    input  ideq_pkg::t_word        i_from_high,
    output ideq_pkg::t_word        o_word
);

    ideq_pkg::t_word r_word;
    ideq_pkg::t_word n_word;

    always_comb begin
        n_word = r_word;
        case (i_ctrl.kind)
            ideq_pkg::K_HOLD: begin
                n_word = r_word;
            end
            ideq_pkg::K_WRITE: begin
                if (i_pos == i_ctrl.pos_a) begin
                    n_word = i_ctrl.word_a;
                end else if (i_pos == i_ctrl.pos_b) begin
                    n_word = i_ctrl.word_b;
                end
            end
            ideq_pkg::K_INSERT: begin
                // entries behind the slot move one place back
                if (i_pos > i_ctrl.pos_a) begin
                    n_word = i_from_low;
                end else if (i_pos == i_ctrl.pos_a) begin
                    n_word = i_ctrl.word_a;
                end
            end
            ideq_pkg::K_REMOVE: begin
                if (i_pos >= i_ctrl.pos_a) begin
                    n_word = i_from_high;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

@@ rtl/core/ideq_rd_tree.sv @@
// two-level registered read selector over the cell row
// depends on ideq_pkg
module ideq_rd_tree (
    input  logic            i_clk,
    input  logic            i_load,
    input  ideq_pkg::t_idx  i_addr,
    input  ideq_pkg::t_word i_words [ideq_pkg::DEPTH],
    output ideq_pkg::t_word o_word
);

    ideq_pkg::t_word                 r_grp [ideq_pkg::NGRP];
    logic [ideq_pkg::HI_W-1:0]       r_hi;

    // first level: one word per group of cells, picked by the low address bits
    for (genvar g = 0; g < ideq_pkg::NGRP; g++) begin : g_grp
        localparam logic [ideq_pkg::HI_W-1:0] GSEL = ideq_pkg::HI_W'(g);
        always_ff @(posedge i_clk) begin
            if (i_load) begin
                r_grp[g] <= i_words[{GSEL, i_addr[ideq_pkg::LO_W-1:0]}];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hi <= i_addr[ideq_pkg::IDX_W-1:ideq_pkg::LO_W];
        end
    end

    // second level: group picked by the high address bits
    assign o_word = r_grp[r_hi];

endmodule

@@ rtl/core/indexed_double_ended_queue.sv @@
// top level of the indexed double-ended queue: command control, cell row, read selectors
// depends on ideq_pkg, ideq_cell and ideq_rd_tree
//
// usage
//   slave channel s_axis carries one command word; master channel m_axis returns
//   exactly one result word for every command, in order
//   the entries live in a row of cells kept in queue order, front in cell 0, so
//   insert and remove shift every entry behind the position together
//   a command is taken in S_IDLE and its operand words are gathered into
//   two registered read selectors (per-group pick, then group pick); in S_EXEC
//   the cells update and the result lands in the output register
//   a new command is not taken until the previous one has updated the cells,
//   as the read select stands ahead of the cell update; every command costs the same
//   a waiting result does not block the next command being taken; only when
//   the output register is still full at the update edge does the block hold
//   there until the receiver takes the pending word
//   reset clears the count and the output valid; cell contents are left as
//   they are and only ever read after being written, so no clearing pass
//   clear empties the queue at once
module indexed_double_ended_queue (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // cmd[3:0], index[11:4], second_index[19:12], value[51:20], zero pad
    input  logic [ideq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // data_out[31:0], status[33:32], count[42:34], zero pad
    output logic [ideq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    localparam int PAD_W = ideq_pkg::OUT_TDATA_W - ideq_pkg::DATA_WIDTH - 2 - ideq_pkg::CNT_W;

    t_state                 r_state;
    t_state                 n_state;
    ideq_pkg::t_cnt         r_count;
    ideq_pkg::t_cnt         n_count;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [ideq_pkg::OUT_TDATA_W-1:0] r_out_tdata;
    logic [ideq_pkg::OUT_TDATA_W-1:0] n_out_tdata;

    logic [3:0]             r_cmd;
    ideq_pkg::t_idx         r_idx;
    ideq_pkg::t_idx         r_idx2;
    ideq_pkg::t_word        r_value;

    // input word fields
    logic [3:0]             in_cmd;
    ideq_pkg::t_idx         in_idx;
    ideq_pkg::t_idx         in_idx2;
    ideq_pkg::t_word        in_value;
    ideq_pkg::t_idx         addr_a;

    logic                   accept;
    logic                   commit;

    ideq_pkg::t_word        cell_words [ideq_pkg::DEPTH];
    ideq_pkg::t_word        low_words  [ideq_pkg::DEPTH];
    ideq_pkg::t_word        high_words [ideq_pkg::DEPTH];
    ideq_pkg::t_cell_ctrl   ctrl;
    ideq_pkg::t_word        rd_a;
    ideq_pkg::t_word        rd_b;

    logic [3:0]             eff_cmd;
    logic                   full;
    logic                   empty;
    logic                   idx_bad;
    logic                   idx2_bad;
    ideq_pkg::t_word        res_data;
    logic [1:0]             res_status;

    assign in_cmd   = s_axis_tdata[3:0];
    assign in_idx   = s_axis_tdata[11:4];
    assign in_idx2  = s_axis_tdata[19:12];
    assign in_value = s_axis_tdata[51:20];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign commit        = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    // operand position for port a: the ends for pops and peeks, else the index
    always_comb begin
        case (in_cmd)
            ideq_pkg::CMD_POP_TAIL,
            ideq_pkg::CMD_PEEK_BACK: begin
                addr_a = ideq_pkg::IDX_W'(r_count - ideq_pkg::CNT_W'(1));
            end
            ideq_pkg::CMD_POP_HEAD,
            ideq_pkg::CMD_PEEK_FRONT: begin
                addr_a = '0;
            end
            default: begin
                addr_a = in_idx;
            end
        endcase
    end

    // cell row, neighbours chained both ways
    for (genvar c = 0; c < ideq_pkg::DEPTH; c++) begin : g_cell
        if (c == 0) begin : g_first
            assign low_words[c] = '0;
        end else begin : g_mid_low
            assign low_words[c] = cell_words[c-1];
        end
        if (c == ideq_pkg::DEPTH - 1) begin : g_last
            assign high_words[c] = cell_words[c];
        end else begin : g_mid_high
            assign high_words[c] = cell_words[c+1];
        end

        ideq_cell u_cell (
            .i_clk       (i_clk),
            .i_pos       (ideq_pkg::IDX_W'(c)),
            .i_ctrl      (ctrl),
            .i_from_low  (low_words[c]),
            .i_from_high (high_words[c]),
            .o_word      (cell_words[c])
        );
    end

    ideq_rd_tree u_rd_a (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_addr  (addr_a),
        .i_words (cell_words),
        .o_word  (rd_a)
    );

    ideq_rd_tree u_rd_b (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_addr  (in_idx2),
        .i_words (cell_words),
        .o_word  (rd_b)
    );

    // command execution on the update edge
    always_comb begin
        full     = (r_count == ideq_pkg::CNT_W'(ideq_pkg::DEPTH));
        empty    = (r_count == '0);
        idx_bad  = ({1'b0, r_idx} >= r_count);
        idx2_bad = ({1'b0, r_idx2} >= r_count);
        // insert at or past the end behaves as push back
        eff_cmd  = ((r_cmd == ideq_pkg::CMD_INSERT) && idx_bad) ? ideq_pkg::CMD_PUSH_TAIL
                                                               : r_cmd;

        ctrl.kind   = ideq_pkg::K_HOLD;
        ctrl.pos_a  = r_idx;
        ctrl.pos_b  = r_idx;
        ctrl.word_a = r_value;
        ctrl.word_b = r_value;
        res_data    = '0;
        res_status  = ideq_pkg::ST_OK;
        n_count     = r_count;

        case (eff_cmd)
            ideq_pkg::CMD_PUSH_TAIL: begin
                if (full) begin
                    res_status = ideq_pkg::ST_FULL;
                end else begin
                    ctrl.kind  = ideq_pkg::K_WRITE;
                    ctrl.pos_a = ideq_pkg::IDX_W'(r_count);
                    ctrl.pos_b = ideq_pkg::IDX_W'(r_count);
                    n_count    = r_count + ideq_pkg::CNT_W'(1);
                end
            end
            ideq_pkg::CMD_PUSH_HEAD: begin
                if (full) begin
                    res_status = ideq_pkg::ST_FULL;
                end else begin
                    ctrl.kind  = ideq_pkg::K_INSERT;
                    ctrl.pos_a = '0;
                    n_count    = r_count + ideq_pkg::CNT_W'(1);
                end
            end
            ideq_pkg::CMD_POP_TAIL: begin
                if (empty) begin
                    res_status = ideq_pkg::ST_EMPTY;
                end else begin
                    res_data = rd_a;
                    n_count  = r_count - ideq_pkg::CNT_W'(1);
                end
            end
            ideq_pkg::CMD_POP_HEAD: begin
                if (empty) begin
                    res_status = ideq_pkg::ST_EMPTY;
                end else begin
                    res_data   = rd_a;
                    ctrl.kind  = ideq_pkg::K_REMOVE;
                    ctrl.pos_a = '0;
                    n_count    = r_count - ideq_pkg::CNT_W'(1);
                end
            end
            ideq_pkg::CMD_READ: begin
                if (idx_bad) begin
                    res_status = ideq_pkg::ST_RANGE;
                end else begin
                    res_data = rd_a;
                end
            end
            ideq_pkg::CMD_WRITE: begin
                if (idx_bad) begin
                    res_status = ideq_pkg::ST_RANGE;
                end else begin
                    ctrl.kind = ideq_pkg::K_WRITE;
                end
            end
            ideq_pkg::CMD_INSERT: begin
                if (full) begin
                    res_status = ideq_pkg::ST_FULL;
                end else begin
                    ctrl.kind = ideq_pkg::K_INSERT;
                    n_count   = r_count + ideq_pkg::CNT_W'(1);
                end
            end
            ideq_pkg::CMD_REMOVE: begin
                if (idx_bad) begin
                    res_status = ideq_pkg::ST_RANGE;
                end else begin
                    res_data  = rd_a;
                    ctrl.kind = ideq_pkg::K_REMOVE;
                    n_count   = r_count - ideq_pkg::CNT_W'(1);
                end
            end
            ideq_pkg::CMD_SWAP: begin
                if (idx_bad || idx2_bad) begin
                    res_status = ideq_pkg::ST_RANGE;
                end else begin
                    // both cells written crosswise together
                    ctrl.kind   = ideq_pkg::K_WRITE;
                    ctrl.pos_b  = r_idx2;
                    ctrl.word_a = rd_b;
                    ctrl.word_b = rd_a;
                end
            end
            ideq_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            ideq_pkg::CMD_PEEK_FRONT,
            ideq_pkg::CMD_PEEK_BACK: begin
                if (empty) begin
                    res_status = ideq_pkg::ST_EMPTY;
                end else begin
                    res_data = rd_a;
                end
            end
            default: begin
                res_status = ideq_pkg::ST_OK;
            end
        endcase

        if (!commit) begin
            ctrl.kind = ideq_pkg::K_HOLD;
            n_count   = r_count;
        end

        n_out_tdata = {PAD_W'(0), n_count, res_status, res_data};
    end

    // sequencing and output register
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= in_cmd;
            r_idx   <= in_idx;
            r_idx2  <= in_idx2;
            r_value <= in_value;
        end
        if (commit) begin
            r_out_tdata <= n_out_tdata;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;

endmodule
